@@ hw/rtl/rscc_pkg.sv @@
// ----------------------------------------------------------------------------
// Read-sampling consensus caller: shared package
// Types and fixed codes used by the draw stages, the call stage and the top.
// ----------------------------------------------------------------------------
package rscc_pkg;

	// Random fraction fields on the input beat, and their width.
	localparam int RAND_N    = 4;
	localparam int RAND_BITS = 16;

	// Configuration register indexes and port widths.
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DEPTH = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DEPTH = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_N_MATCHES = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_N_DRAWS   = 2'd3;

	// Register reset values.
	localparam logic [15:0] MIN_DEPTH_RST = 16'd3;
	localparam logic [15:0] MAX_DEPTH_RST = 16'd100;
	localparam logic [2:0]  N_MATCHES_RST = 3'd2;
	localparam logic [2:0]  N_DRAWS_RST   = 3'd3;

	// Base positions in the count and tally vectors.
	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	// Call codes.
	localparam logic [2:0] CALL_N = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_CALLED = 2'd0;
	localparam logic [1:0] ST_NO_MAJ = 2'd1;
	localparam logic [1:0] ST_DEPTH  = 2'd2;
	localparam logic [1:0] ST_BAD    = 2'd3;

	// Per-item control that travels down the draw stages.
	typedef struct packed {
		logic             in_range;
		logic             bad;
		logic [2:0]       draws;
		logic [3:0][2:0]  tally;
	} ctl_t;

	// One finished result.
	typedef struct packed {
		logic [2:0]       call;
		logic [1:0]       status;
		logic [3:0][2:0]  tally;
	} res_t;

endpackage

@@ hw/rtl/rscc_draw.sv @@
// ----------------------------------------------------------------------------
// Read-sampling consensus caller: one draw
// Two pipeline stages: scaled index and running count sums, then base
// selection with count and tally update.
// ----------------------------------------------------------------------------
module rscc_draw #(
	parameter int COUNT_BITS = 16,
	parameter int IDX        = 0
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                en,
	input  logic                                                in_vld,
	input  rscc_pkg::ctl_t                                      in_ctl,
	input  logic [COUNT_BITS-1:0]                               in_depth,
	input  logic [3:0][COUNT_BITS-1:0]                          in_cnt,
	input  logic [rscc_pkg::RAND_N-1:0][rscc_pkg::RAND_BITS-1:0] in_rnd,
	output logic                                                out_vld,
	output rscc_pkg::ctl_t                                      out_ctl,
	output logic [COUNT_BITS-1:0]                               out_depth,
	output logic [3:0][COUNT_BITS-1:0]                          out_cnt,
	output logic [rscc_pkg::RAND_N-1:0][rscc_pkg::RAND_BITS-1:0] out_rnd
);

	localparam int PW = COUNT_BITS + rscc_pkg::RAND_BITS;
	localparam int SW = COUNT_BITS + 2;

	logic [COUNT_BITS-1:0]   remain;
	logic [PW-1:0]           prod;
	logic [SW-1:0]           sum_tg;
	logic [SW-1:0]           sum_ca;
	logic [3:0][SW-1:0]      cum;

	logic                    vld_s1;
	rscc_pkg::ctl_t          ctl_s1;
	logic [COUNT_BITS-1:0]   depth_s1;
	logic [3:0][COUNT_BITS-1:0] cnt_s1;
	logic [rscc_pkg::RAND_N-1:0][rscc_pkg::RAND_BITS-1:0] rnd_s1;
	logic [COUNT_BITS-1:0]   idx_s1;
	logic [3:0][SW-1:0]      cum_s1;

	logic                    act;
	logic                    hit;
	logic [1:0]              sel;
	logic [SW-1:0]           idx_ext;
	rscc_pkg::ctl_t          nxt_ctl;
	logic [3:0][COUNT_BITS-1:0] nxt_cnt;

	logic                    vld_s2;
	rscc_pkg::ctl_t          ctl_s2;
	logic [COUNT_BITS-1:0]   depth_s2;
	logic [3:0][COUNT_BITS-1:0] cnt_s2;
	logic [rscc_pkg::RAND_N-1:0][rscc_pkg::RAND_BITS-1:0] rnd_s2;

	// First half: index into the remaining reads, and the running sums of the
	// counts taken from T downward.
	always_comb begin
		remain = in_depth - COUNT_BITS'(IDX);
		prod   = PW'(in_rnd[IDX]) * PW'(remain);
		sum_tg = SW'(in_cnt[rscc_pkg::BASE_T]) + SW'(in_cnt[rscc_pkg::BASE_G]);
		sum_ca = SW'(in_cnt[rscc_pkg::BASE_C]) + SW'(in_cnt[rscc_pkg::BASE_A]);
		cum[0] = SW'(in_cnt[rscc_pkg::BASE_T]);
		cum[1] = sum_tg;
		cum[2] = sum_tg + SW'(in_cnt[rscc_pkg::BASE_C]);
		cum[3] = sum_tg + sum_ca;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1   <= in_ctl;
			depth_s1 <= in_depth;
			cnt_s1   <= in_cnt;
			rnd_s1   <= in_rnd;
			idx_s1   <= prod[PW-1:rscc_pkg::RAND_BITS];
			cum_s1   <= cum;
		end
	end

	// Second half: the first running sum above the index names the base.
	// An index past the total means the counts do not add up to the depth.
	always_comb begin
		act     = ctl_s1.in_range && !ctl_s1.bad && (3'(IDX) < ctl_s1.draws);
		idx_ext = SW'(idx_s1);
		hit     = 1'b1;
		sel     = rscc_pkg::BASE_T;
		if (idx_ext < cum_s1[0]) begin
			sel = rscc_pkg::BASE_T;
		end else if (idx_ext < cum_s1[1]) begin
			sel = rscc_pkg::BASE_G;
		end else if (idx_ext < cum_s1[2]) begin
			sel = rscc_pkg::BASE_C;
		end else if (idx_ext < cum_s1[3]) begin
			sel = rscc_pkg::BASE_A;
		end else begin
			hit = 1'b0;
		end
		nxt_ctl = ctl_s1;
		nxt_cnt = cnt_s1;
		if (act) begin
			if (hit) begin
				nxt_cnt[sel]       = cnt_s1[sel] - COUNT_BITS'(1);
				nxt_ctl.tally[sel] = ctl_s1.tally[sel] + 3'd1;
			end else begin
				nxt_ctl.bad = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2   <= nxt_ctl;
			depth_s2 <= depth_s1;
			cnt_s2   <= nxt_cnt;
			rnd_s2   <= rnd_s1;
		end
	end

	assign out_vld   = vld_s2;
	assign out_ctl   = ctl_s2;
	assign out_depth = depth_s2;
	assign out_cnt   = cnt_s2;
	assign out_rnd   = rnd_s2;

endmodule

@@ hw/rtl/rscc_call.sv @@
// ----------------------------------------------------------------------------
// Read-sampling consensus caller: call stage
// Picks the called base from the tallies and holds the result in an output
// register backed by a skid register.
// ----------------------------------------------------------------------------
module rscc_call (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  rscc_pkg::ctl_t in_ctl,
	input  logic [2:0]     min_votes,
	output logic           en,
	output logic           out_valid,
	input  logic           out_ready,
	output rscc_pkg::res_t out_res
);

	rscc_pkg::res_t res;
	logic           found;

	rscc_pkg::res_t res_q;
	logic           res_vld_q;
	rscc_pkg::res_t skid_q;
	logic           skid_vld_q;

	logic           take;
	logic           o_free;

	always_comb begin
		found      = 1'b0;
		res.tally  = in_ctl.tally;
		res.call   = rscc_pkg::CALL_N;
		res.status = rscc_pkg::ST_NO_MAJ;
		if (!in_ctl.in_range) begin
			res.tally  = '0;
			res.status = rscc_pkg::ST_DEPTH;
		end else if (in_ctl.bad) begin
			res.status = rscc_pkg::ST_BAD;
		end else begin
			for (int b = 0; b < 4; b++) begin
				if (!found && (in_ctl.tally[b] >= min_votes)) begin
					found      = 1'b1;
					res.call   = 3'(b);
					res.status = rscc_pkg::ST_CALLED;
				end
			end
		end
	end

	// The pipeline moves only while the skid register is empty.
	assign en     = !skid_vld_q;
	assign take   = en && in_vld;
	assign o_free = !res_vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (o_free) begin
			if (skid_vld_q) begin
				res_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				res_vld_q <= take;
			end
		end else if (take) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (o_free) begin
			if (skid_vld_q) begin
				res_q <= skid_q;
			end else if (take) begin
				res_q <= res;
			end
		end else if (take) begin
			skid_q <= res;
		end
	end

	assign out_valid = res_vld_q;
	assign out_res   = res_q;

endmodule

@@ hw/rtl/read_sampling_consensus_call.sv @@
// ----------------------------------------------------------------------------
// Read-sampling consensus caller
// Calls one genome position from its base counts by sampling reads without
// replacement and requiring enough agreeing samples.
// ----------------------------------------------------------------------------
// The block takes one position per clock while in_ready is high, and
// returns one result per position, in order. The chain holds
// min(MAX_DRAWS, 4) draws: every draw occupies two pipeline stages (a
// 16 x COUNT_BITS multiply for the scaled index next to the running count
// sums, then base selection and count update), and the call stage writes
// the output register. A skid register behind the output keeps the input
// side moving for one more beat when the output stalls, and in_ready
// comes straight from a flop. Configuration registers are meant to be
// written only while no position is in flight.
module read_sampling_consensus_call #(
	parameter int MAX_DRAWS  = 4,
	parameter int COUNT_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_wr_en,
	input  logic [rscc_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [rscc_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [COUNT_BITS-1:0]                   depth,
	input  logic [COUNT_BITS-1:0]                   count_a,
	input  logic [COUNT_BITS-1:0]                   count_c,
	input  logic [COUNT_BITS-1:0]                   count_g,
	input  logic [COUNT_BITS-1:0]                   count_t,
	input  logic [rscc_pkg::RAND_BITS-1:0]          rand_0,
	input  logic [rscc_pkg::RAND_BITS-1:0]          rand_1,
	input  logic [rscc_pkg::RAND_BITS-1:0]          rand_2,
	input  logic [rscc_pkg::RAND_BITS-1:0]          rand_3,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [2:0]                              base_call,
	output logic [1:0]                              status,
	output logic [2:0]                              sampled_a,
	output logic [2:0]                              sampled_c,
	output logic [2:0]                              sampled_g,
	output logic [2:0]                              sampled_t
);

	localparam int NDRAW = (MAX_DRAWS < rscc_pkg::RAND_N) ? MAX_DRAWS : rscc_pkg::RAND_N;
	localparam int CW    = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	logic [15:0] min_depth_q;
	logic [15:0] max_depth_q;
	logic [2:0]  min_votes_q;
	logic [2:0]  n_draws_q;

	logic                    en;
	logic [CW-1:0]           depth_ext;
	logic [2:0]              nd;
	rscc_pkg::ctl_t          entry_ctl;

	logic                    vld_c   [NDRAW+1];
	rscc_pkg::ctl_t          ctl_c   [NDRAW+1];
	logic [COUNT_BITS-1:0]   depth_c [NDRAW+1];
	logic [3:0][COUNT_BITS-1:0] cnt_c [NDRAW+1];
	logic [rscc_pkg::RAND_N-1:0][rscc_pkg::RAND_BITS-1:0] rnd_c [NDRAW+1];

	rscc_pkg::res_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_depth_q <= rscc_pkg::MIN_DEPTH_RST;
			max_depth_q <= rscc_pkg::MAX_DEPTH_RST;
			min_votes_q <= rscc_pkg::N_MATCHES_RST;
			n_draws_q   <= rscc_pkg::N_DRAWS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rscc_pkg::REG_MIN_DEPTH: min_depth_q <= cfg_wdata[15:0];
				rscc_pkg::REG_MAX_DEPTH: max_depth_q <= cfg_wdata[15:0];
				rscc_pkg::REG_N_MATCHES: min_votes_q <= cfg_wdata[2:0];
				rscc_pkg::REG_N_DRAWS:   n_draws_q   <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// Range check and the number of draws, capped by depth and by the stages
	// that exist.
	always_comb begin
		depth_ext = CW'(depth);
		nd        = n_draws_q;
		if (depth_ext < CW'(n_draws_q)) begin
			nd = depth[2:0];
		end
		if (nd > 3'(NDRAW)) begin
			nd = 3'(NDRAW);
		end
		entry_ctl.in_range = (depth_ext >= CW'(min_depth_q)) &&
			(depth_ext <= CW'(max_depth_q));
		entry_ctl.bad      = 1'b0;
		entry_ctl.draws    = nd;
		entry_ctl.tally    = '0;
	end

	assign in_ready   = en;
	assign vld_c[0]   = in_valid && en;
	assign ctl_c[0]   = entry_ctl;
	assign depth_c[0] = depth;
	assign cnt_c[0]   = {count_t, count_g, count_c, count_a};
	assign rnd_c[0]   = {rand_3, rand_2, rand_1, rand_0};

	for (genvar k = 0; k < NDRAW; k++) begin : g_draw
		rscc_draw #(
			.COUNT_BITS (COUNT_BITS),
			.IDX        (k)
		) u_draw (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_vld    (vld_c[k]),
			.in_ctl    (ctl_c[k]),
			.in_depth  (depth_c[k]),
			.in_cnt    (cnt_c[k]),
			.in_rnd    (rnd_c[k]),
			.out_vld   (vld_c[k+1]),
			.out_ctl   (ctl_c[k+1]),
			.out_depth (depth_c[k+1]),
			.out_cnt   (cnt_c[k+1]),
			.out_rnd   (rnd_c[k+1])
		);
	end

	rscc_call u_call (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (vld_c[NDRAW]),
		.in_ctl    (ctl_c[NDRAW]),
		.min_votes (min_votes_q),
		.en        (en),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res)
	);

	assign base_call = res.call;
	assign status    = res.status;
	assign sampled_a = res.tally[rscc_pkg::BASE_A];
	assign sampled_c = res.tally[rscc_pkg::BASE_C];
	assign sampled_g = res.tally[rscc_pkg::BASE_G];
	assign sampled_t = res.tally[rscc_pkg::BASE_T];

endmodule
